@@ hdl/jsd_pkg.sv @@
package jsd_pkg;

    // Field and register widths fixed by the register map and result format.
    localparam int CENTER_W   = 10;
    localparam int DEAD_W     = 9;
    localparam int IVL_W      = 8;
    localparam int REV_W      = 8;
    localparam int COIL_W     = 4;
    localparam int PHASE_W    = 3;
    localparam int DIST_W     = 9;
    localparam int PROD_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Full-scale deflection past the dead band.
    localparam logic [DIST_W-1:0] SPAN = 9'd412;

    // Division by 412 is done as a shift by two, then a multiply by the
    // rounded-up reciprocal of 103 scaled by 2^29. It is exact for every
    // product this block can form.
    localparam int                RECIP_W     = 23;
    localparam int                RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5212339;
    localparam int                QUOT_W      = (PROD_W - 2) + RECIP_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVLIM = 3'd4;

    // Register values after reset.
    localparam logic [CENTER_W-1:0] RST_CENTER = 10'd500;
    localparam logic [DEAD_W-1:0]   RST_DEAD   = 9'd100;
    localparam logic [IVL_W-1:0]    RST_SLOW   = 8'd20;
    localparam logic [IVL_W-1:0]    RST_FAST   = 8'd1;
    localparam logic [REV_W-1:0]    RST_REVLIM = 8'd128;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [DEAD_W-1:0]   dead;
        logic [IVL_W-1:0]    slow;
        logic [IVL_W-1:0]    fast;
        logic [REV_W-1:0]    rev_limit;
    } t_cfg;

    // One classified sample handed from the front end to the controller.
    typedef struct packed {
        logic [IVL_W-1:0] interval;
        logic             moving;
        logic             cw;
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_INIT = 3'b001,
        MODE_WAIT = 3'b010,
        MODE_RUN  = 3'b100
    } t_mode;

    // Eight-phase half-step coil sequence.
    function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            3'd7: pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/jsd_sample_if.sv @@
interface jsd_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] joystick_y;

    modport source (output valid, output joystick_y, input ready);
    modport sink   (input valid, input joystick_y, output ready);
endinterface

@@ hdl/jsd_result_if.sv @@
interface jsd_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_pattern;
    logic       running;
    logic       clockwise;

    modport source (output valid, output coil_pattern, output running, output clockwise,
                    input ready);
    modport sink   (input valid, input coil_pattern, input running, input clockwise,
                    output ready);
endinterface

@@ hdl/joystick_stepper_driver.sv @@
// Channel    Dir  Port       Payload
// sample     in   i_sample   joystick_y (SAMPLE_BITS)
// result     out  o_result   coil_pattern (4), running (1), clockwise (1)
// config     in   i_cfg_*    register index (3), data (10), write enable
//
// One word is accepted per cycle and one result word leaves per cycle when
// neither side stalls. A sample passes through the front-end pipe (classify, multiply,
// reciprocal multiply) and then the queue, and its result word shows in the controller's
// output register once the controller takes it from the queue.
// Synchronous active-low reset restores the config registers and control state to defaults.
// A stalled output backs up into a four-word queue before the front end stops taking samples.
module joystick_stepper_driver #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    jsd_sample_if.sink                        i_sample,
    jsd_result_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [jsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import jsd_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd back_cmd;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_ready;

    // Register bank. Writes to indexes past the last register are dropped and
    // the data is cut to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center    <= RST_CENTER;
            r_cfg.dead      <= RST_DEAD;
            r_cfg.slow      <= RST_SLOW;
            r_cfg.fast      <= RST_FAST;
            r_cfg.rev_limit <= RST_REVLIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER: r_cfg.center    <= i_cfg_data[CENTER_W-1:0];
                REG_DEAD:   r_cfg.dead      <= i_cfg_data[DEAD_W-1:0];
                REG_SLOW:   r_cfg.slow      <= i_cfg_data[IVL_W-1:0];
                REG_FAST:   r_cfg.fast      <= i_cfg_data[IVL_W-1:0];
                REG_REVLIM: r_cfg.rev_limit <= i_cfg_data[REV_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: works out direction and step interval for each sample.
    jsd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_cfg       (r_cfg),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready)
    );

    // Short queue so the controller and the front end can stall separately.
    jsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (front_cmd),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .o_cmd        (back_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready)
    );

    // Controller: init, wait and run modes, step timer and coil sequencing.
    jsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (back_ready),
        .i_rev_limit (r_cfg.rev_limit),
        .o_result    (o_result)
    );

    // Coils are always released while the motor is not running.
    a_coils_off_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.running) |-> (o_result.coil_pattern == '0))
        else $error("coils driven while not running");

    // A half-step pattern never energises more than two adjacent coils.
    a_coil_pattern_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ($countones(o_result.coil_pattern) <= 2))
        else $error("illegal coil pattern");

    // A stalled result word keeps the coil pattern it showed.
    a_coil_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=> $stable(o_result.coil_pattern))
        else $error("coil pattern changed under stall");

endmodule

@@ hdl/jsd_front.sv @@
module jsd_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jsd_sample_if.sink   i_sample,
    input  jsd_pkg::t_cfg i_cfg,
    output jsd_pkg::t_cmd o_cmd,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready
);
    import jsd_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > CENTER_W + 1) ? SAMPLE_BITS : CENTER_W + 1;

    logic                  adv;
    logic [CMP_W-1:0]      y_ext;
    logic [CMP_W-1:0]      lo;
    logic [CMP_W-1:0]      hi;
    logic [CMP_W-1:0]      dist_raw;
    logic [DIST_W-1:0]     dist_clamp;
    logic                  below;
    logic                  above;
    logic [IVL_W-1:0]      fast_c;
    logic [IVL_W-1:0]      diff;
    logic [QUOT_W-1:0]     quot_full;
    logic [IVL_W-1:0]      quot;

    // Stage one: classification and clamped distance.
    logic                  r_s1_vld;
    logic [DIST_W-1:0]     r_s1_dist;
    logic                  r_s1_move;
    logic                  r_s1_cw;
    // Stage two: distance times speed range.
    logic                  r_s2_vld;
    logic [PROD_W-1:0]     r_s2_prod;
    logic                  r_s2_move;
    logic                  r_s2_cw;
    // Stage three: finished command.
    logic                  r_s3_vld;
    t_cmd                  r_s3_cmd;

    // The pipe moves as a whole whenever its last stage is empty or drained.
    assign adv            = !r_s3_vld || i_cmd_ready;
    assign i_sample.ready = adv;
    assign o_cmd_valid    = r_s3_vld;
    assign o_cmd          = r_s3_cmd;

    always_comb begin
        y_ext = CMP_W'(i_sample.joystick_y);
        lo    = (i_cfg.center > CENTER_W'(i_cfg.dead))
                ? CMP_W'(i_cfg.center - CENTER_W'(i_cfg.dead)) : '0;
        hi    = CMP_W'(i_cfg.center) + CMP_W'(i_cfg.dead);
        below = y_ext < lo;
        above = !below && (y_ext > hi);
        dist_raw   = below ? (lo - y_ext) : (y_ext - hi);
        dist_clamp = (dist_raw > CMP_W'(SPAN)) ? SPAN : dist_raw[DIST_W-1:0];

        fast_c = (i_cfg.fast > i_cfg.slow) ? i_cfg.slow : i_cfg.fast;
        diff   = i_cfg.slow - fast_c;

        quot_full = QUOT_W'(r_s2_prod[PROD_W-1:2]) * QUOT_W'(RECIP_MULT);
        quot      = quot_full[RECIP_SHIFT +: IVL_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_sample.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_dist <= dist_clamp;
            r_s1_move <= below || above;
            r_s1_cw   <= below;

            r_s2_prod <= PROD_W'(r_s1_dist) * PROD_W'(diff);
            r_s2_move <= r_s1_move;
            r_s2_cw   <= r_s1_cw;

            r_s3_cmd.interval <= i_cfg.slow - quot;
            r_s3_cmd.moving   <= r_s2_move;
            r_s3_cmd.cw       <= r_s2_cw;
        end
    end

endmodule

@@ hdl/jsd_queue.sv @@
module jsd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsd_pkg::t_cmd i_cmd,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output jsd_pkg::t_cmd o_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);
    import jsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_cmd        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hdl/jsd_back.sv @@
module jsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jsd_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic [jsd_pkg::REV_W-1:0]   i_rev_limit,
    jsd_result_if.source                o_result
);
    import jsd_pkg::*;

    t_mode              r_mode;
    logic [PHASE_W-1:0] r_phase;
    logic [IVL_W-1:0]   r_timer;
    logic [REV_W-1:0]   r_rev;
    logic [COIL_W-1:0]  r_coil;
    logic               r_cw;
    logic               r_out_vld;

    t_mode              n_mode;
    logic [PHASE_W-1:0] n_phase;
    logic [IVL_W-1:0]   n_timer;
    logic [REV_W-1:0]   n_rev;
    logic [COIL_W-1:0]  n_coil;
    logic               n_cw;
    logic               take;
    logic               fire;

    // The controller state doubles as the output word, so a new command is
    // taken whenever the word on show is gone or being taken.
    assign take        = !r_out_vld || o_result.ready;
    assign o_cmd_ready = take;
    assign fire        = i_cmd_valid && take;

    assign o_result.valid        = r_out_vld;
    assign o_result.coil_pattern = r_coil;
    assign o_result.running      = r_mode == MODE_RUN;
    assign o_result.clockwise    = r_cw;

    always_comb begin
        logic [IVL_W-1:0] tick;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_timer = r_timer;
        n_rev   = r_rev;
        n_coil  = r_coil;
        n_cw    = r_cw;
        tick    = '0;
        if (fire) begin
            n_cw = i_cmd.cw;
            case (r_mode)
                MODE_INIT: begin
                    if (i_cmd.moving) begin
                        n_rev   = '0;
                        n_phase = '0;
                        n_timer = '0;
                        n_mode  = MODE_RUN;
                    end else begin
                        n_mode = MODE_WAIT;
                    end
                end
                MODE_WAIT: begin
                    if (i_cmd.moving) begin
                        n_mode = MODE_RUN;
                    end
                end
                MODE_RUN: begin
                    if (!i_cmd.moving || r_rev >= i_rev_limit) begin
                        n_rev   = '0;
                        n_phase = '0;
                        n_mode  = MODE_WAIT;
                    end
                end
                default: begin
                    n_mode = MODE_INIT;
                end
            endcase

            if (n_mode == MODE_RUN) begin
                tick = n_timer + 1'b1;
                if (tick >= i_cmd.interval) begin
                    n_timer = '0;
                    n_coil  = half_step(i_cmd.cw ? n_phase : ~n_phase);
                    if (n_phase == '1) begin
                        n_rev = n_rev + 1'b1;
                    end
                    n_phase = n_phase + 1'b1;
                end else begin
                    n_timer = tick;
                end
            end else begin
                n_coil = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INIT;
            r_phase   <= '0;
            r_timer   <= '0;
            r_rev     <= '0;
            r_coil    <= '0;
            r_cw      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_rev   <= n_rev;
            r_coil  <= n_coil;
            r_cw    <= n_cw;
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule
